// File: hw/rtl/y86ex_pkg.sv
package y86ex_pkg;

   // Instruction codes.
   localparam logic [3:0] ICODE_HALT   = 4'd0;
   localparam logic [3:0] ICODE_NOP    = 4'd1;
   localparam logic [3:0] ICODE_RRMOVQ = 4'd2;
   localparam logic [3:0] ICODE_IRMOVQ = 4'd3;
   localparam logic [3:0] ICODE_RMMOVQ = 4'd4;
   localparam logic [3:0] ICODE_MRMOVQ = 4'd5;
   localparam logic [3:0] ICODE_OPQ    = 4'd6;
   localparam logic [3:0] ICODE_JXX    = 4'd7;
   localparam logic [3:0] ICODE_CALL   = 4'd8;
   localparam logic [3:0] ICODE_RET    = 4'd9;
   localparam logic [3:0] ICODE_PUSHQ  = 4'd10;
   localparam logic [3:0] ICODE_POPQ   = 4'd11;

   // ALU functions.
   localparam logic [3:0] ALU_ADD = 4'd0;
   localparam logic [3:0] ALU_SUB = 4'd1;
   localparam logic [3:0] ALU_AND = 4'd2;
   localparam logic [3:0] ALU_XOR = 4'd3;

   // Condition codes.
   localparam logic [3:0] COND_ALWAYS = 4'd0;
   localparam logic [3:0] COND_LE     = 4'd1;
   localparam logic [3:0] COND_L      = 4'd2;
   localparam logic [3:0] COND_E      = 4'd3;
   localparam logic [3:0] COND_NE     = 4'd4;
   localparam logic [3:0] COND_GE     = 4'd5;
   localparam logic [3:0] COND_G      = 4'd6;

   localparam logic [3:0]  REG_NONE  = 4'hF;
   localparam logic [1:0]  STAT_AOK  = 2'd0;
   localparam logic [63:0] NEG_EIGHT = 64'hFFFF_FFFF_FFFF_FFF8;
   localparam logic [63:0] POS_EIGHT = 64'd8;

   typedef struct packed {
      logic [3:0]  mode;
      logic [3:0]  func_code;
      logic [63:0] value_a;
      logic [63:0] value_b;
      logic [63:0] value_c;
      logic [3:0]  dest_e_in;
      logic [3:0]  dest_m_in;
      logic [1:0]  status_in;
      logic [1:0]  mem_status;
      logic [1:0]  wb_status;
      logic [3:0]  decode_src_a;
      logic [3:0]  decode_src_b;
   } req_type;

   typedef struct packed {
      logic [63:0] value_e;
      logic        cond_true;
      logic [3:0]  dest_e_out;
      logic [63:0] value_a_out;
      logic [3:0]  dest_m_out;
      logic [1:0]  status_out;
      logic [3:0]  instr_code_out;
      logic        flags_updated;
      logic        insert_bubble;
   } rsp_type;

   typedef struct packed {
      logic zero;
      logic sign;
      logic overflow;
   } flags_type;

   localparam flags_type FLAGS_RESET = '{zero: 1'b1, sign: 1'b0, overflow: 1'b0};

endpackage

// File: hw/rtl/y86ex_chan_if.sv
interface y86ex_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/y86ex_alu.sv
module y86ex_alu (
   input  y86ex_pkg::req_type   req,
   input  y86ex_pkg::flags_type flags,
   output y86ex_pkg::rsp_type   rsp,
   output y86ex_pkg::flags_type flags_next
);
   logic [63:0] op_a;
   logic [63:0] op_b;
   logic [3:0]  alu_fn;
   logic [63:0] sum;
   logic [63:0] diff;
   logic [63:0] result;
   logic        ovf;
   logic        less;
   logic        cond;
   logic        update;

   always_comb begin
      unique case (req.mode)
         y86ex_pkg::ICODE_RRMOVQ, y86ex_pkg::ICODE_OPQ: op_a = req.value_a;
         y86ex_pkg::ICODE_IRMOVQ, y86ex_pkg::ICODE_RMMOVQ,
         y86ex_pkg::ICODE_MRMOVQ:                       op_a = req.value_c;
         y86ex_pkg::ICODE_CALL, y86ex_pkg::ICODE_PUSHQ: op_a = y86ex_pkg::NEG_EIGHT;
         y86ex_pkg::ICODE_RET, y86ex_pkg::ICODE_POPQ:   op_a = y86ex_pkg::POS_EIGHT;
         default:                                       op_a = '0;
      endcase
      unique case (req.mode)
         y86ex_pkg::ICODE_RMMOVQ, y86ex_pkg::ICODE_MRMOVQ, y86ex_pkg::ICODE_OPQ,
         y86ex_pkg::ICODE_CALL, y86ex_pkg::ICODE_RET, y86ex_pkg::ICODE_PUSHQ,
         y86ex_pkg::ICODE_POPQ: op_b = req.value_b;
         default:               op_b = '0;
      endcase
   end

   assign alu_fn = (req.mode == y86ex_pkg::ICODE_OPQ) ? req.func_code : y86ex_pkg::ALU_ADD;
   assign sum    = op_a + op_b;
   assign diff   = op_b - op_a;

   always_comb begin
      result = '0;
      ovf    = 1'b0;
      if (req.mode != y86ex_pkg::ICODE_JXX) begin
         unique case (alu_fn)
            y86ex_pkg::ALU_ADD: begin
               result = sum;
               ovf    = (op_a[63] == op_b[63]) && (sum[63] != op_a[63]);
            end
            y86ex_pkg::ALU_SUB: begin
               result = diff;
               ovf    = (op_a[63] != op_b[63]) && (diff[63] != op_b[63]);
            end
            y86ex_pkg::ALU_AND: result = op_a & op_b;
            y86ex_pkg::ALU_XOR: result = op_a ^ op_b;
            default:            result = '0;
         endcase
      end
   end

   // Conditions use the flags as they stood before this instruction.
   assign less = flags.sign ^ flags.overflow;

   always_comb begin
      unique case (req.func_code)
         y86ex_pkg::COND_LE: cond = flags.zero | less;
         y86ex_pkg::COND_L:  cond = less;
         y86ex_pkg::COND_E:  cond = flags.zero;
         y86ex_pkg::COND_NE: cond = ~flags.zero;
         y86ex_pkg::COND_GE: cond = ~less;
         y86ex_pkg::COND_G:  cond = ~flags.zero & ~less;
         default:            cond = 1'b1;
      endcase
   end

   assign update = (req.mode == y86ex_pkg::ICODE_OPQ)
                   && (req.mem_status == y86ex_pkg::STAT_AOK)
                   && (req.wb_status == y86ex_pkg::STAT_AOK);

   always_comb begin
      flags_next = flags;
      if (update) begin
         flags_next.zero     = (result == '0);
         flags_next.sign     = result[63];
         flags_next.overflow = ovf;
      end
   end

   always_comb begin
      rsp.value_e        = result;
      rsp.cond_true      = cond;
      rsp.dest_e_out     = (req.mode == y86ex_pkg::ICODE_RRMOVQ && !cond)
                           ? y86ex_pkg::REG_NONE : req.dest_e_in;
      rsp.value_a_out    = req.value_a;
      rsp.dest_m_out     = req.dest_m_in;
      rsp.status_out     = req.status_in;
      rsp.instr_code_out = req.mode;
      rsp.flags_updated  = update;
      rsp.insert_bubble  = (req.mode == y86ex_pkg::ICODE_JXX && !cond)
                           || ((req.mode == y86ex_pkg::ICODE_MRMOVQ
                                || req.mode == y86ex_pkg::ICODE_POPQ)
                               && (req.dest_m_in == req.decode_src_a
                                   || req.dest_m_in == req.decode_src_b));
   end
endmodule

// File: hw/rtl/y86_execute_stage_unit.sv
// Y86-64 execute stage: input register, ALU and condition logic, result register.
// A request is held in the input register while the combinational ALU works on
// it, and the result is then loaded into the result register for the response.
// Throughput: one request per cycle while the response side keeps taking results.
// Reset (synchronous, active high) empties both registers and sets ZF=1,
// SF=0, OF=0.
module y86_execute_stage_unit (
   input  logic      clock,
   input  logic      reset,
   y86ex_chan_if.sink   req_bus,
   y86ex_chan_if.source rsp_bus
);
   // Input register. It fills whenever it is empty or moving on this cycle.
   logic                 in_valid_ff, in_valid_in;
   y86ex_pkg::req_type   in_data_ff;

   // Result register, which parts the request side from the response side.
   logic                 out_valid_ff, out_valid_in;
   y86ex_pkg::rsp_type   out_data_ff;

   // Condition codes are architectural state. They are written only when an
   // instruction leaves the input register, so later instructions always see
   // the flags produced by every earlier one.
   y86ex_pkg::flags_type flags_ff, flags_in;

   y86ex_pkg::rsp_type   alu_rsp;
   y86ex_pkg::flags_type alu_flags;

   logic out_load;
   logic in_advance;
   logic in_load;

   assign out_load   = !out_valid_ff || rsp_bus.ready;
   assign in_advance = in_valid_ff && out_load;
   assign in_load    = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !in_valid_ff || out_load;

   y86ex_alu u_alu (
      .req        (in_data_ff),
      .flags      (flags_ff),
      .rsp        (alu_rsp),
      .flags_next (alu_flags)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      flags_in     = flags_ff;
      if (in_advance || !in_valid_ff) begin
         in_valid_in = in_load;
      end
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
      if (in_advance) begin
         flags_in = alu_flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= y86ex_pkg::FLAGS_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_bus.data;
      end
      if (in_advance) begin
         out_data_ff <= alu_rsp;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_data_ff;

`ifndef NO_ASSERTIONS
   // Flags move only when an updating instruction leaves the input register.
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !(in_advance && alu_rsp.flags_updated) |=> $stable(flags_ff))
      else $error("condition codes changed without an updating instruction");

   // An instruction that leaves the input register lands in the result register.
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      in_advance |=> out_valid_ff)
      else $error("advanced request lost before the result register");

   // A not-taken jump always asks for a bubble.
   a_jump_bubble: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.instr_code_out == y86ex_pkg::ICODE_JXX
       && !out_data_ff.cond_true) |-> out_data_ff.insert_bubble)
      else $error("mispredicted jump without bubble");

   // A not-taken conditional move writes no register.
   a_cmov_cancel: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.instr_code_out == y86ex_pkg::ICODE_RRMOVQ
       && !out_data_ff.cond_true) |-> (out_data_ff.dest_e_out == y86ex_pkg::REG_NONE))
      else $error("not-taken conditional move kept its destination");
`endif
endmodule

// File: tb/tb_y86_execute_stage_unit.sv
`timescale 1ns / 100ps

// Checks the execute stage against a cycle-free model of the same stage. The model
// keeps its own copy of the ZF/SF/OF condition codes and works out each response
// when its request is accepted. The directed table comes first, then a long
// random run. Both sides of the pipe idle at random, except in one steady stretch.
module tb_y86_execute_stage_unit;
   import y86ex_pkg::*;

   // Status codes beyond AOK, and the top 4-bit code, which is used as an
   // undefined opcode, an undefined ALU function and a condition above G.
   localparam logic [1:0] STAT_ADR = 2'd1;
   localparam logic [1:0] STAT_INS = 2'd2;
   localparam logic [1:0] STAT_HLT = 2'd3;
   localparam logic [3:0] CODE_TOP = 4'hF;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam int RANDOM_REQUESTS = 2000;

   // One row of the directed table. Where typed is set, the expected ALU result,
   // condition, destination, flag write and bubble are written out in the row.
   // The pass-through fields always come from the request itself. Other rows are
   // checked against the model.
   typedef struct packed {
      logic [3:0]  mode;
      logic [3:0]  fn;
      logic [63:0] va;
      logic [63:0] vb;
      logic [63:0] vc;
      logic [3:0]  dste;
      logic [3:0]  dstm;
      logic [1:0]  st;
      logic [1:0]  mst;
      logic [1:0]  wst;
      logic [3:0]  sa;
      logic [3:0]  sb;
      logic        typed;
      logic [63:0] e;
      logic        cnd;
      logic [3:0]  dste_out;
      logic        upd;
      logic        bub;
   } stim_row_type;

   // Flags after reset are ZF=1, SF=0, OF=0. Some row comments give the flags that
   // the row leaves behind where it changes them.
   localparam int DIRECTED_COUNT = 25;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // A jump on equal is taken straight after reset, because ZF starts at 1.
      '{ICODE_JXX, COND_E, ALL_ONES, ALL_ONES, ALL_ONES, REG_NONE, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, 64'd0, 1'b1, REG_NONE, 1'b0, 1'b0},
      // A cmovne that is not taken cancels its destination.
      '{ICODE_RRMOVQ, COND_NE, MAX_POS, ALL_ONES, 64'd0, 4'd3, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, MAX_POS, 1'b0, REG_NONE, 1'b0, 1'b0},
      '{ICODE_RRMOVQ, COND_LE, MIN_NEG, 64'd0, 64'd0, 4'd2, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, MIN_NEG, 1'b1, 4'd2, 1'b0, 1'b0},
      // An add that wraps to zero without signed overflow: Z1 S0 O0.
      '{ICODE_OPQ, ALU_ADD, 64'd1, ALL_ONES, 64'd0, 4'd5, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd1, 4'd2, 1'b1, 64'd0, 1'b1, 4'd5, 1'b1, 1'b0},
      // MIN_NEG minus one overflows: Z0 S0 O1.
      '{ICODE_OPQ, ALU_SUB, 64'd1, MIN_NEG, 64'd0, 4'd6, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, MAX_POS, 1'b1, 4'd6, 1'b1, 1'b0},
      // Less is SF xor OF, so jl is taken and jge is not, which asks for a bubble.
      '{ICODE_JXX, COND_L, 64'd0, 64'd0, 64'h40, REG_NONE, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, 64'd0, 1'b1, REG_NONE, 1'b0, 1'b0},
      '{ICODE_JXX, COND_GE, 64'd0, 64'd0, 64'h80, REG_NONE, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, 64'd0, 1'b0, REG_NONE, 1'b0, 1'b1},
      '{ICODE_OPQ, ALU_ADD, MAX_POS, 64'd1, 64'd0, 4'd7, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      '{ICODE_OPQ, ALU_AND, ALL_ONES, ALL_ONES, 64'd0, 4'd0, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      '{ICODE_OPQ, ALU_XOR, ALL_ONES, ALL_ONES, 64'd0, 4'd1, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      '{ICODE_OPQ, ALU_SUB, 64'd1, 64'd0, 64'd0, 4'd4, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      // An undefined ALU function gives zero and still writes the flags: Z1 S0 O0.
      '{ICODE_OPQ, CODE_TOP, ALL_ONES, ALL_ONES, ALL_ONES, 4'd8, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, 64'd0, 1'b1, 4'd8, 1'b1, 1'b0},
      // A bad status in the memory or writeback stage blocks the flag write.
      '{ICODE_OPQ, ALU_ADD, 64'd1, 64'd1, 64'd0, 4'd9, REG_NONE,
        STAT_INS, STAT_ADR, STAT_AOK, 4'd0, 4'd0, 1'b1, 64'd2, 1'b1, 4'd9, 1'b0, 1'b0},
      '{ICODE_OPQ, ALU_ADD, 64'd0, 64'd0, 64'd0, 4'd10, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_HLT, 4'd0, 4'd0, 1'b1, 64'd0, 1'b1, 4'd10, 1'b0, 1'b0},
      // The status of the instruction itself does not block the write.
      '{ICODE_OPQ, ALU_ADD, 64'd0, 64'd0, 64'd0, 4'd11, REG_NONE,
        STAT_HLT, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, 64'd0, 1'b1, 4'd11, 1'b1, 1'b0},
      // Load/use hazards, including one where the load destination and both sources are "none".
      '{ICODE_MRMOVQ, COND_ALWAYS, ALL_ONES, 64'd16, 64'd8, REG_NONE, 4'd3,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd3, 4'd7, 1'b1, 64'd24, 1'b1, REG_NONE, 1'b0, 1'b1},
      '{ICODE_POPQ, COND_ALWAYS, 64'd0, ALL_ONES, 64'd0, 4'd4, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, REG_NONE, REG_NONE, 1'b1, 64'd7, 1'b1, 4'd4, 1'b0, 1'b1},
      '{ICODE_MRMOVQ, COND_ALWAYS, 64'd0, MIN_NEG, MAX_POS, REG_NONE, 4'd4,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd1, 4'd4, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      // Stack pointer arithmetic.
      '{ICODE_CALL, COND_ALWAYS, 64'd0, 64'd8, 64'h1234, 4'd4, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      '{ICODE_PUSHQ, COND_ALWAYS, ALL_ONES, MIN_NEG, 64'd0, 4'd4, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      '{ICODE_RET, COND_G, 64'd0, ALL_ONES, 64'd0, 4'd4, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      // Displacement and immediate paths.
      '{ICODE_IRMOVQ, COND_ALWAYS, 64'd3, 64'd5, ALL_ONES, 4'd12, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      '{ICODE_RMMOVQ, COND_ALWAYS, MAX_POS, MIN_NEG, MIN_NEG, REG_NONE, REG_NONE,
        STAT_AOK, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b0, 64'd0, 1'b0, 4'd0, 1'b0, 1'b0},
      // Halt and an undefined opcode both give a zero ALU result.
      '{ICODE_HALT, CODE_TOP, ALL_ONES, ALL_ONES, ALL_ONES, 4'd0, 4'd0,
        STAT_HLT, STAT_AOK, STAT_AOK, 4'd0, 4'd0, 1'b1, 64'd0, 1'b1, 4'd0, 1'b0, 1'b0},
      '{CODE_TOP, COND_NE, ALL_ONES, ALL_ONES, ALL_ONES, 4'd13, 4'd13,
        STAT_ADR, STAT_INS, STAT_HLT, 4'd13, 4'd13, 1'b1, 64'd0, 1'b0, 4'd13, 1'b0, 1'b0}
   };

   logic clock;
   logic reset;

   y86ex_chan_if #(.payload_type(req_type)) req_bus ();
   y86ex_chan_if #(.payload_type(rsp_type)) rsp_bus ();

   y86_execute_stage_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // This is the model's copy of the condition codes, and the responses that
   // are still on their way through the pipe, oldest first.
   flags_type cc_flags;
   rsp_type   pending_results[$];
   int        error_count;
   bit        steady;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The watchdog allows several times the slowest legal run.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // This is the execute stage with no pipeline timing. The condition is taken
   // from the flags as they stood before this instruction. Only an OPq whose
   // memory and writeback stages are both AOK writes new flags.
   function automatic rsp_type execute_result(input req_type r);
      logic [63:0] alu_a;
      logic [63:0] alu_b;
      logic [63:0] alu_e;
      logic [3:0]  alu_fn;
      logic        ovf;
      logic        less;
      logic        taken;
      logic        write_flags;
      rsp_type     o;
      alu_a  = '0;
      alu_b  = '0;
      alu_e  = '0;
      alu_fn = ALU_ADD;
      ovf    = 1'b0;
      case (r.mode)
         ICODE_RRMOVQ, ICODE_OPQ: alu_a = r.value_a;
         ICODE_IRMOVQ, ICODE_RMMOVQ, ICODE_MRMOVQ: alu_a = r.value_c;
         ICODE_CALL, ICODE_PUSHQ: alu_a = NEG_EIGHT;
         ICODE_RET, ICODE_POPQ: alu_a = POS_EIGHT;
         default: alu_a = '0;
      endcase
      case (r.mode)
         ICODE_RMMOVQ, ICODE_MRMOVQ, ICODE_OPQ, ICODE_CALL, ICODE_RET,
         ICODE_PUSHQ, ICODE_POPQ: alu_b = r.value_b;
         default: alu_b = '0;
      endcase
      if (r.mode == ICODE_OPQ) alu_fn = r.func_code;

      less = cc_flags.sign ^ cc_flags.overflow;
      case (r.func_code)
         COND_LE: taken = cc_flags.zero | less;
         COND_L:  taken = less;
         COND_E:  taken = cc_flags.zero;
         COND_NE: taken = ~cc_flags.zero;
         COND_GE: taken = ~less;
         COND_G:  taken = ~cc_flags.zero & ~less;
         default: taken = 1'b1;
      endcase

      // A jump gives a zero result, because the stale adder output is not passed on.
      if (r.mode != ICODE_JXX) begin
         case (alu_fn)
            ALU_ADD: begin
               alu_e = alu_a + alu_b;
               ovf   = (alu_a[63] == alu_b[63]) && (alu_e[63] != alu_a[63]);
            end
            ALU_SUB: begin
               alu_e = alu_b - alu_a;
               ovf   = (alu_a[63] != alu_b[63]) && (alu_e[63] != alu_b[63]);
            end
            ALU_AND: alu_e = alu_a & alu_b;
            ALU_XOR: alu_e = alu_a ^ alu_b;
            default: alu_e = '0;
         endcase
      end

      write_flags = (r.mode == ICODE_OPQ) && (r.mem_status == STAT_AOK)
                    && (r.wb_status == STAT_AOK);
      if (write_flags) begin
         cc_flags.zero     = (alu_e == '0);
         cc_flags.sign     = alu_e[63];
         cc_flags.overflow = ovf;
      end

      o.value_e        = alu_e;
      o.cond_true      = taken;
      o.dest_e_out     = (r.mode == ICODE_RRMOVQ && !taken) ? REG_NONE : r.dest_e_in;
      o.value_a_out    = r.value_a;
      o.dest_m_out     = r.dest_m_in;
      o.status_out     = r.status_in;
      o.instr_code_out = r.mode;
      o.flags_updated  = write_flags;
      o.insert_bubble  = (r.mode == ICODE_JXX && !taken)
                         || ((r.mode == ICODE_MRMOVQ || r.mode == ICODE_POPQ)
                             && (r.dest_m_in == r.decode_src_a
                                 || r.dest_m_in == r.decode_src_b));
      return o;
   endfunction

   // Operand values favor the corners: all ones, the sign boundary, small
   // numbers and single bits. Mixed in are fully random words.
   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 7))
         0: return ALL_ONES;
         1: return MIN_NEG;
         2: return MAX_POS;
         3: return 64'($urandom_range(0, 16));
         4: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // The mix leans on OPq, jumps and cmov, since those are the instructions that
   // move the flags and read them back. Undefined opcodes and functions appear
   // now and then.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 19);
      if (pick < 2)       r.mode = 4'($urandom_range(12, 15));
      else if (pick < 8)  r.mode = ICODE_OPQ;
      else if (pick < 11) r.mode = ICODE_JXX;
      else if (pick < 13) r.mode = ICODE_RRMOVQ;
      else                r.mode = 4'($urandom_range(0, 11));
      if ($urandom_range(0, 9) < 8)
         r.func_code = (r.mode == ICODE_OPQ) ? 4'($urandom_range(0, 3))
                                             : 4'($urandom_range(0, 6));
      else
         r.func_code = 4'($urandom);
      r.value_a    = random_word();
      r.value_b    = random_word();
      r.value_c    = random_word();
      r.dest_e_in  = 4'($urandom);
      r.dest_m_in  = 4'($urandom);
      r.status_in  = 2'($urandom);
      r.mem_status = ($urandom_range(0, 9) < 8) ? STAT_AOK : 2'($urandom);
      r.wb_status  = ($urandom_range(0, 9) < 8) ? STAT_AOK : 2'($urandom);
      r.decode_src_a = ($urandom_range(0, 9) < 3) ? r.dest_m_in : 4'($urandom);
      r.decode_src_b = ($urandom_range(0, 9) < 3) ? r.dest_m_in : 4'($urandom);
      return r;
   endfunction

   // This task is called at a rising edge. It holds valid until the request is
   // accepted, then queues the expected response. Outside the steady stretch it
   // sometimes drops valid afterward. When the next request follows at once, valid
   // simply stays high, so it gets only one assignment in that time step.
   task automatic issue_request(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_bus.valid <= 1'b1;
      req_bus.data  <= r;
      do @(posedge clock); while (!req_bus.ready);
      predicted = execute_result(r);
      pending_results.push_back(typed ? typed_rsp : predicted);
      if (!steady && $urandom_range(0, 99) < 33) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // On the response side, each accepted response is checked against the oldest
   // expectation. Outside the steady stretch, ready is drawn again on every cycle,
   // so stalls fall on every phase of the pipe.
   always @(posedge clock) begin : response_check
      rsp_type want;
      rsp_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("ERROR: response with nothing expected: %p", got);
            end else begin
               want = pending_results.pop_front();
               if (got.value_e !== want.value_e || got.cond_true !== want.cond_true
                   || got.dest_e_out !== want.dest_e_out
                   || got.value_a_out !== want.value_a_out
                   || got.dest_m_out !== want.dest_m_out
                   || got.status_out !== want.status_out
                   || got.instr_code_out !== want.instr_code_out
                   || got.flags_updated !== want.flags_updated
                   || got.insert_bubble !== want.insert_bubble) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("ERROR: response mismatch at %0t", $realtime);
                     $display("  expected: %p", want);
                     $display("  actual:   %p", got);
                  end
               end
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 33);
      end
   end

   initial begin : stimulus
      req_type      r;
      rsp_type      typed_rsp;
      stim_row_type row;
      cc_flags      = FLAGS_RESET;
      error_count   = 0;
      steady        = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table: corner values, every opcode except NOP, the flag write rules
      // and both hazard sources.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         r.mode         = row.mode;
         r.func_code    = row.fn;
         r.value_a      = row.va;
         r.value_b      = row.vb;
         r.value_c      = row.vc;
         r.dest_e_in    = row.dste;
         r.dest_m_in    = row.dstm;
         r.status_in    = row.st;
         r.mem_status   = row.mst;
         r.wb_status    = row.wst;
         r.decode_src_a = row.sa;
         r.decode_src_b = row.sb;
         typed_rsp.value_e        = row.e;
         typed_rsp.cond_true      = row.cnd;
         typed_rsp.dest_e_out     = row.dste_out;
         typed_rsp.value_a_out    = row.va;
         typed_rsp.dest_m_out     = row.dstm;
         typed_rsp.status_out     = row.st;
         typed_rsp.instr_code_out = row.mode;
         typed_rsp.flags_updated  = row.upd;
         typed_rsp.insert_bubble  = row.bub;
         issue_request(r, row.typed, typed_rsp);
      end

      // Random run. One stretch runs with no idling on either side, to keep the
      // pipe full, and later the sender lets the pipe drain completely once.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == 700) steady = 1'b1;
         if (i == 1000) steady = 1'b0;
         if (i == 1500) begin
            req_bus.valid <= 1'b0;
            wait (pending_results.size() == 0);
            @(posedge clock);
         end
         issue_request(random_request(), 1'b0, typed_rsp);
      end
      req_bus.valid <= 1'b0;

      // Let the last responses come out. A further wait catches any response
      // that should not be there.
      wait (pending_results.size() == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
